[hw/rtl/dwh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwh_pkg
// Shared widths and constants for the densified winner-take-all hash block.
// ----------------------------------------------------------------------------
package dwh_pkg;

  // Request field widths
  localparam int IDX_W    = 20;
  localparam int BIN_ID_W = 16;
  localparam int VAL_W    = 32;

  // Result field widths
  localparam int SLOT_W = 5;

  // Configuration port
  localparam int MULT_W  = 31;
  localparam int PDATA_W = 32;
  localparam int PADDR_W = 3;

  // Register word indexes
  localparam logic [0:0] REG_PROBE_MULT = 1'b0;

  // Probe hash: t = ((bin + 1) << PROBE_BIN_SHIFT) + count,
  // h = ((m * t) << PROBE_PRE_SHIFT) mod 2^32 >> (32 - LOG_BINS)
  localparam int PROBE_BIN_SHIFT = 6;
  localparam int PROBE_PRE_SHIFT = 3;
  localparam int HASH_W          = 32;

  // Probe product bits that survive the pre-shift
  localparam int PROD_W = HASH_W - PROBE_PRE_SHIFT;

endpackage

[hw/rtl/dwh_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwh_in_if / dwh_out_if
// Valid/ready channels carrying element requests and per-bin hash results.
// ----------------------------------------------------------------------------
interface dwh_in_if;
  logic                              valid;
  logic                              ready;
  logic [dwh_pkg::IDX_W-1:0]         element_index;
  logic [dwh_pkg::BIN_ID_W-1:0]      bin_id;
  logic signed [dwh_pkg::VAL_W-1:0]  value;
  logic                              last;

  modport source (output valid, element_index, bin_id, value, last, input ready);
  modport sink   (input valid, element_index, bin_id, value, last, output ready);
endinterface

interface dwh_out_if;
  logic                          valid;
  logic                          ready;
  logic [dwh_pkg::SLOT_W-1:0]    slot;
  logic [dwh_pkg::IDX_W-1:0]     hash_index;
  logic                          failed;
  logic                          last_result;

  modport source (output valid, slot, hash_index, failed, last_result, input ready);
  modport sink   (input valid, slot, hash_index, failed, last_result, output ready);
endinterface

[hw/rtl/densified_wta_hash.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// densified_wta_hash
// Streams sparse elements into per-bin winner registers, then emits one
// densified hash per bin, probing empty bins through a shared multiplier.
// ----------------------------------------------------------------------------
// Absorb: a bin store read, then compare and write back; no new element is
// accepted until the write back is done. Emit: a filled bin passes check,
//   store read and output; an empty bin passes check, then per probe (up to
//   MAX_PROBES) a multiply and a clamp and check, then a store read on a hit,
//   then output, plus any output stall.
// Reset (rst_n low, synchronous): all bins empty, multiplier = 1, idle.
// ----------------------------------------------------------------------------
module densified_wta_hash #(
  parameter int NUM_BINS   = 32,
  parameter int LOG_BINS   = 5,
  parameter int MAX_PROBES = 101
) (
  input  logic                         clk,
  input  logic                         rst_n,
  dwh_in_if.sink                       in_if,
  dwh_out_if.source                    out_if,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [dwh_pkg::PADDR_W-1:0]  cfg_paddr,
  input  logic [dwh_pkg::PDATA_W-1:0]  cfg_pwdata,
  output logic [dwh_pkg::PDATA_W-1:0]  cfg_prdata,
  output logic                         cfg_pready
);

  localparam int BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int CNT_W = $clog2(MAX_PROBES + 1);
  localparam int T_W   = BIN_W + 8;
  localparam int MUL_W = dwh_pkg::MULT_W + T_W;
  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_ABSORB    = 3'd1;
  localparam logic [2:0] S_EMIT_CHK  = 3'd2;
  localparam logic [2:0] S_PROBE_MUL = 3'd3;
  localparam logic [2:0] S_PROBE_CHK = 3'd4;
  localparam logic [2:0] S_EMIT_RD   = 3'd5;
  localparam logic [2:0] S_OUT       = 3'd6;

  // Control state
  logic [2:0]                  state_r, state_nxt;
  logic [BIN_W-1:0]            b_r, b_nxt;
  logic [CNT_W-1:0]            c_r, c_nxt;
  logic [NUM_BINS-1:0]         filled_r, filled_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [dwh_pkg::MULT_W-1:0]  mult_r;

  // Latched request
  logic [dwh_pkg::IDX_W-1:0]         idx_r;
  logic [BIN_W-1:0]                  bin_r;
  logic                              bin_ok_r;
  logic signed [dwh_pkg::VAL_W-1:0]  value_r;
  logic                              last_r;

  // Bin store
  logic signed [dwh_pkg::VAL_W-1:0]  mem_val [NUM_BINS];
  logic [dwh_pkg::IDX_W-1:0]         mem_idx [NUM_BINS];
  logic signed [dwh_pkg::VAL_W-1:0]  rd_val_r;
  logic [dwh_pkg::IDX_W-1:0]         rd_idx_r;
  logic [BIN_W-1:0]                  rd_addr;

  // Probe datapath
  logic [T_W-1:0]              probe_t;
  logic [MUL_W-1:0]            prod_full;
  logic [dwh_pkg::PROD_W-1:0]  prod_r;
  logic [LOG_BINS-1:0]         probe_h;
  logic [7:0]                  probe_h8;
  logic [BIN_W-1:0]            probe_q;

  // Result register
  logic [dwh_pkg::SLOT_W-1:0]  out_slot_r;
  logic [dwh_pkg::IDX_W-1:0]   out_idx_r;
  logic                        out_failed_r;
  logic                        out_last_r;

  logic in_fire, out_fire, bin_ok, win, we, load_hit, load_fail, cfg_wr;

  // Handshakes
  assign in_if.ready = (state_r == S_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_fire    = out_valid_r && out_if.ready;
  assign bin_ok      = (in_if.bin_id < dwh_pkg::BIN_ID_W'(NUM_BINS));

  assign out_if.valid       = out_valid_r;
  assign out_if.slot        = out_slot_r;
  assign out_if.hash_index  = out_idx_r;
  assign out_if.failed      = out_failed_r;
  assign out_if.last_result = out_last_r;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == dwh_pkg::REG_PROBE_MULT) ?
                      dwh_pkg::PDATA_W'(mult_r) : '0;

  // Probe hash: one multiply, then clamp the top bits to the last bin
  assign probe_t   = ((T_W'(b_r) + T_W'(1)) << dwh_pkg::PROBE_BIN_SHIFT) + T_W'(c_r);
  assign prod_full = MUL_W'(mult_r) * MUL_W'(probe_t);
  assign probe_h   = prod_r[dwh_pkg::PROD_W-1 -: LOG_BINS];
  assign probe_h8  = 8'(probe_h);
  assign probe_q   = (probe_h8 > 8'(NUM_BINS - 1)) ? LAST_BIN : BIN_W'(probe_h8);

  // Replace on an empty bin or a strictly larger value
  assign win = bin_ok_r && (!filled_r[bin_r] || (value_r > rd_val_r));
  assign we  = (state_r == S_ABSORB) && win;

  // Select the store read address
  always_comb begin
    case (state_r)
      S_IDLE:      rd_addr = BIN_W'(in_if.bin_id);
      S_EMIT_CHK:  rd_addr = b_r;
      S_PROBE_CHK: rd_addr = probe_q;
      default:     rd_addr = bin_r;
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    filled_nxt    = filled_r;
    out_valid_nxt = out_valid_r;
    load_hit      = 1'b0;
    load_fail     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_ABSORB;
      end
      S_ABSORB: begin
        if (win) filled_nxt[bin_r] = 1'b1;
        b_nxt     = '0;
        state_nxt = last_r ? S_EMIT_CHK : S_IDLE;
      end
      S_EMIT_CHK: begin
        if (filled_r[b_r]) begin
          state_nxt = S_EMIT_RD;
        end else begin
          c_nxt     = CNT_W'(1);
          state_nxt = S_PROBE_MUL;
        end
      end
      S_PROBE_MUL: begin
        state_nxt = S_PROBE_CHK;
      end
      S_PROBE_CHK: begin
        if (filled_r[probe_q]) begin
          state_nxt = S_EMIT_RD;
        end else if (c_r == CNT_W'(MAX_PROBES)) begin
          load_fail     = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          c_nxt     = c_r + CNT_W'(1);
          state_nxt = S_PROBE_MUL;
        end
      end
      S_EMIT_RD: begin
        load_hit      = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (out_fire) begin
          out_valid_nxt = 1'b0;
          if (b_r == LAST_BIN) begin
            filled_nxt = '0;
            state_nxt  = S_IDLE;
          end else begin
            b_nxt     = b_r + BIN_W'(1);
            state_nxt = S_EMIT_CHK;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      b_r         <= '0;
      c_r         <= '0;
      filled_r    <= '0;
      out_valid_r <= 1'b0;
      mult_r      <= dwh_pkg::MULT_W'(1);
    end else begin
      state_r     <= state_nxt;
      b_r         <= b_nxt;
      c_r         <= c_nxt;
      filled_r    <= filled_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr && (cfg_paddr[2] == dwh_pkg::REG_PROBE_MULT)) begin
        mult_r <= cfg_pwdata[dwh_pkg::MULT_W-1:0];
      end
    end
  end

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (in_fire) begin
      idx_r    <= in_if.element_index;
      bin_r    <= BIN_W'(in_if.bin_id);
      bin_ok_r <= bin_ok;
      value_r  <= in_if.value;
      last_r   <= in_if.last;
    end
  end

  // Bin store: one write, one registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_val[bin_r] <= value_r;
      mem_idx[bin_r] <= idx_r;
    end
    rd_val_r <= mem_val[rd_addr];
    rd_idx_r <= mem_idx[rd_addr];
  end

  // Register the probe product
  always_ff @(posedge clk) begin
    if (state_r == S_PROBE_MUL) prod_r <= prod_full[dwh_pkg::PROD_W-1:0];
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (load_hit || load_fail) begin
      out_slot_r   <= dwh_pkg::SLOT_W'(b_r);
      out_idx_r    <= load_hit ? rd_idx_r : '0;
      out_failed_r <= load_fail;
      out_last_r   <= (b_r == LAST_BIN);
    end
  end

  // Store is empty right after the final result leaves
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_last_r) |=> (filled_r == '0))
    else $error("bin store not cleared after final result");

  // No request is taken while a result is pending
  a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> !out_valid_r)
    else $error("request accepted while result pending");

  // Probe count stays within its bound
  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE_CHK) |-> ((c_r >= CNT_W'(1)) && (c_r <= CNT_W'(MAX_PROBES))))
    else $error("probe count out of range");

endmodule

[bench/densified_wta_hash_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// densified_wta_hash_tb
// Streams sparse element vectors into the densified winner-take-all hash
// block and checks every per-bin hash it emits. A behavioral model tracks
// the per-bin winners and the multiplier, replays the densification probes
// on each last element, and queues the 32 expected hashes, which the result
// monitor compares in order. Directed tests cover replacement rules, empty
// and ignored bins, probe failure and multiplier extremes. Random vectors
// then run under three input/output stall profiles.
// ----------------------------------------------------------------------------
module densified_wta_hash_tb;

  localparam int BINS        = 32;
  localparam int LOG_BINS    = 5;
  localparam int MAX_PROBES  = 101;
  localparam int RAND_ITEMS  = 125;      // counted elements per stall profile
  localparam int DRAIN_PAUSE = 12;
  // Worst case: ~470 requests, each last-marked, 32 results each, every result
  // an empty bin running all probes plus a long output stall.
  localparam int CYCLE_LIMIT = 20_000_000;

  localparam logic [dwh_pkg::PADDR_W-1:0] MULT_ADDR =
    dwh_pkg::PADDR_W'({dwh_pkg::REG_PROBE_MULT, 2'b00});
  localparam logic signed [dwh_pkg::VAL_W-1:0] VAL_MIN =
    {1'b1, {(dwh_pkg::VAL_W-1){1'b0}}};
  localparam logic signed [dwh_pkg::VAL_W-1:0] VAL_MAX =
    {1'b0, {(dwh_pkg::VAL_W-1){1'b1}}};

  typedef struct {
    logic [dwh_pkg::IDX_W-1:0]        index;
    logic [dwh_pkg::BIN_ID_W-1:0]     bin;
    logic signed [dwh_pkg::VAL_W-1:0] value;
    logic                             last;
  } element_t;

  typedef struct {
    logic [dwh_pkg::SLOT_W-1:0] slot;
    logic [dwh_pkg::IDX_W-1:0]  hash_index;
    logic                       failed;
    logic                       last_result;
  } bin_hash_t;

  logic clk;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [dwh_pkg::PADDR_W-1:0] cfg_paddr;
  logic [dwh_pkg::PDATA_W-1:0] cfg_pwdata;
  logic [dwh_pkg::PDATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  dwh_in_if  elem_ch ();
  dwh_out_if hash_ch ();

  densified_wta_hash #(
    .NUM_BINS   (BINS),
    .LOG_BINS   (LOG_BINS),
    .MAX_PROBES (MAX_PROBES)
  ) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (elem_ch),
    .out_if      (hash_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Model state: per-bin winners and the probe multiplier
  logic signed [dwh_pkg::VAL_W-1:0] win_value [BINS];
  logic [dwh_pkg::IDX_W-1:0]        win_index [BINS];
  logic                             win_seen  [BINS];
  logic [dwh_pkg::MULT_W-1:0]       probe_mult;

  bin_hash_t pending_hashes[$];
  int        mismatch_count;
  int        cycle_count;
  int        send_idle_pct;
  int        recv_idle_pct;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ERROR: watchdog expired after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result-side backpressure
  always @(negedge clk) begin
    hash_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Compare each accepted hash with the oldest expected one
  always @(posedge clk) begin
    if (rst_n && hash_ch.valid && hash_ch.ready) begin
      if (pending_hashes.size() == 0) begin
        report_mismatch($sformatf("unexpected result slot=%0d index=%h failed=%b last=%b",
          hash_ch.slot, hash_ch.hash_index, hash_ch.failed, hash_ch.last_result));
      end else begin
        bin_hash_t want;
        want = pending_hashes.pop_front();
        if (hash_ch.slot !== want.slot || hash_ch.hash_index !== want.hash_index ||
            hash_ch.failed !== want.failed || hash_ch.last_result !== want.last_result)
          report_mismatch($sformatf(
            "slot %0d: got slot=%0d index=%h failed=%b last=%b, want index=%h failed=%b last=%b",
            want.slot, hash_ch.slot, hash_ch.hash_index, hash_ch.failed,
            hash_ch.last_result, want.hash_index, want.failed, want.last_result));
      end
    end
  end

  function automatic void clear_winners();
    for (int b = 0; b < BINS; b++) begin
      win_value[b] = VAL_MIN;
      win_index[b] = '0;
      win_seen[b]  = 1'b0;
    end
  endfunction

  // Probe target: multiplicative hash of (bin, count), top bits, clamped
  function automatic int unsigned probe_target(int unsigned bin, int unsigned count);
    logic [dwh_pkg::HASH_W-1:0] seed;
    logic [dwh_pkg::HASH_W-1:0] prod;
    logic [dwh_pkg::HASH_W-1:0] top;
    seed = dwh_pkg::HASH_W'(((bin + 1) << dwh_pkg::PROBE_BIN_SHIFT) + count);
    prod = dwh_pkg::HASH_W'({1'b0, probe_mult} * seed);
    prod = prod << dwh_pkg::PROBE_PRE_SHIFT;
    top  = prod >> (dwh_pkg::HASH_W - LOG_BINS);
    if (top > BINS - 1) top = BINS - 1;
    return top;
  endfunction

  // Absorb one accepted element; on last, queue one hash per bin and clear
  function automatic void absorb_element(element_t e);
    bin_hash_t h;
    if (e.bin < BINS) begin
      if (!win_seen[e.bin] || e.value > win_value[e.bin]) begin
        win_value[e.bin] = e.value;
        win_index[e.bin] = e.index;
        win_seen[e.bin]  = 1'b1;
      end
    end
    if (!e.last) return;
    for (int b = 0; b < BINS; b++) begin
      h.slot        = dwh_pkg::SLOT_W'(b);
      h.hash_index  = '0;
      h.failed      = 1'b0;
      h.last_result = (b == BINS - 1);
      if (win_seen[b]) begin
        h.hash_index = win_index[b];
      end else begin
        h.failed = 1'b1;
        for (int c = 1; c <= MAX_PROBES; c++) begin
          int unsigned q;
          q = probe_target(b, c);
          if (win_seen[q]) begin
            h.hash_index = win_index[q];
            h.failed     = 1'b0;
            break;
          end
        end
      end
      pending_hashes = {pending_hashes, h};
    end
    clear_winners();
  endfunction

  // Send one request; returns at the falling edge after acceptance, valid held
  task automatic send_element(element_t e);
    while ($urandom_range(99) < send_idle_pct) begin
      elem_ch.valid = 1'b0;
      @(negedge clk);
    end
    elem_ch.valid         = 1'b1;
    elem_ch.element_index = e.index;
    elem_ch.bin_id        = e.bin;
    elem_ch.value         = e.value;
    elem_ch.last          = e.last;
    @(posedge clk);
    while (!elem_ch.ready) @(posedge clk);
    absorb_element(e);
    @(negedge clk);
  endtask

  task automatic send_fields(logic [dwh_pkg::IDX_W-1:0] idx,
                             logic [dwh_pkg::BIN_ID_W-1:0] bin,
                             logic signed [dwh_pkg::VAL_W-1:0] val, logic last);
    element_t e;
    e.index = idx;
    e.bin   = bin;
    e.value = val;
    e.last  = last;
    send_element(e);
  endtask

  // Drop valid, wait for all expected hashes, then let the block settle
  task automatic wait_drained();
    elem_ch.valid = 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_multiplier(logic [dwh_pkg::PDATA_W-1:0] data);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = MULT_ADDR;
    cfg_pwdata  = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    probe_mult = data[dwh_pkg::MULT_W-1:0];
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // Empty vectors: a lone ignored element with last still emits, all failed
  task automatic test_empty_vector();
    send_fields(20'h00000, dwh_pkg::BIN_ID_W'(BINS), VAL_MAX, 1'b1);
    send_fields(20'hFFFFF, 16'hFFFF, 32'sd0, 1'b1);
    wait_drained();
  endtask

  // Empty bin takes the most negative value, ties keep the earlier element,
  // strictly larger values replace, out-of-range bins are ignored
  task automatic test_replacement_rules();
    send_fields(20'h00011, 16'd0,   VAL_MIN, 1'b0);
    send_fields(20'h00022, 16'd0,   VAL_MIN, 1'b0);
    send_fields(20'h00033, 16'd31,  VAL_MAX, 1'b0);
    send_fields(20'h00044, 16'd31,  VAL_MAX, 1'b0);
    send_fields(20'h00055, 16'd5,   -32'sd1, 1'b0);
    send_fields(20'hFFFFF, 16'd5,   32'sd0,  1'b0);
    send_fields(20'h00066, 16'd5,   -32'sd1, 1'b0);
    send_fields(20'h00077, 16'd32,  VAL_MAX, 1'b0);
    send_fields(20'h00088, 16'h8000, VAL_MAX, 1'b0);
    send_fields(20'h00099, 16'd17,  32'sh0001_0000, 1'b1);
    wait_drained();
  endtask

  // With the reset multiplier every probe lands on bin 0: leave it empty
  task automatic test_probe_failure();
    send_fields(20'hFFFFF, 16'd7, 32'sh7FFF_0000, 1'b0);
    send_fields(20'h12345, 16'd40, 32'sd5, 1'b1);
    wait_drained();
  endtask

  // Multiplier extremes: zero, all ones (bit 31 dropped), then a random odd one
  task automatic test_probe_multiplier();
    write_multiplier(32'h0000_0000);
    send_fields(20'h0ABCD, 16'd0,  32'sd100, 1'b0);
    send_fields(20'h0BCDE, 16'd9,  32'sd100, 1'b1);
    wait_drained();
    write_multiplier(32'hFFFF_FFFF);
    send_fields(20'h54321, 16'd3,  -32'sd7, 1'b0);
    send_fields(20'h6789A, 16'd28, 32'sd7,  1'b1);
    wait_drained();
    write_multiplier({1'($urandom_range(1)), 31'($urandom) | 31'd1});
    send_fields(20'h0F0F0, 16'd12, 32'sd1, 1'b1);
    wait_drained();
  endtask

  // One random vector; returns the number of in-range elements sent
  task automatic send_random_vector(output int counted);
    int len;
    int bin_base;
    bit narrow_bins;
    bit tie_values;
    element_t e;
    counted = 0;
    case ($urandom_range(9))
      0, 1, 2: len = $urandom_range(1, 3);
      3, 4, 5, 6: len = $urandom_range(4, 16);
      default: len = $urandom_range(17, 48);
    endcase
    narrow_bins = ($urandom_range(3) == 0);
    tie_values  = ($urandom_range(3) == 0);
    bin_base    = $urandom_range(BINS - 4);
    for (int i = 0; i < len; i++) begin
      e.index = dwh_pkg::IDX_W'($urandom);
      if ($urandom_range(99) < 8) begin
        // noise: bin id at or above the bin count
        e.bin = ($urandom_range(1)) ? dwh_pkg::BIN_ID_W'($urandom_range(BINS, 16'hFFFF))
                                    : (dwh_pkg::BIN_ID_W'($urandom) | 16'h8000);
      end else begin
        e.bin = narrow_bins ? dwh_pkg::BIN_ID_W'(bin_base + $urandom_range(3))
                            : dwh_pkg::BIN_ID_W'($urandom_range(BINS - 1));
        counted++;
      end
      if (tie_values) begin
        case ($urandom_range(4))
          0: e.value = VAL_MIN;
          1: e.value = VAL_MAX;
          2: e.value = -32'sd1;
          3: e.value = 32'sd0;
          default: e.value = 32'sh0001_0000;
        endcase
      end else begin
        e.value = $urandom;
      end
      e.last = (i == len - 1);
      send_element(e);
    end
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct,
                                     logic [dwh_pkg::PDATA_W-1:0] mult);
    int total;
    int n;
    write_multiplier(mult);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    total = 0;
    while (total < RAND_ITEMS) begin
      send_random_vector(n);
      total += n;
    end
    wait_drained();
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    elem_ch.valid  = 1'b0;
    elem_ch.element_index = '0;
    elem_ch.bin_id = '0;
    elem_ch.value  = '0;
    elem_ch.last   = 1'b0;
    hash_ch.ready  = 1'b0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    probe_mult     = dwh_pkg::MULT_W'(1);
    clear_winners();

    // Hold reset, then release on a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_empty_vector();
    test_replacement_rules();
    test_probe_failure();
    test_probe_multiplier();
    test_random_traffic(7, 73, {1'($urandom_range(1)), 31'($urandom) | 31'd1});
    test_random_traffic(73, 7, $urandom);
    test_random_traffic(0, 0, $urandom);

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/dwh_pkg.sv
hw/rtl/dwh_if.sv
hw/rtl/densified_wta_hash.sv
bench/densified_wta_hash_tb.sv
